// File: hdl/mtep_pkg.sv
`default_nettype none
package mtep_pkg;

  localparam int unsigned SysexKeep = 20;
  localparam int unsigned QueueDepth = 4;

  // Status bytes and meta event types that the parser acts on.
  localparam logic [7:0] StSysex   = 8'hF0;
  localparam logic [7:0] StMeta    = 8'hFF;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [7:0] MetaEot   = 8'h2F;

  typedef enum logic [2:0] {
    EV_CHAN      = 3'd0,
    EV_SYX_BYTE  = 3'd1,
    EV_SYX_END   = 3'd2,
    EV_TEMPO     = 3'd3,
    EV_END_TRACK = 3'd4,
    EV_EXHAUSTED = 3'd5,
    EV_STRAY     = 3'd6
  } ev_kind_t;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b0000000001,
    PH_DELTA     = 10'b0000000010,
    PH_STATUS    = 10'b0000000100,
    PH_DATA1     = 10'b0000001000,
    PH_DATA2     = 10'b0000010000,
    PH_SYX_LEN   = 10'b0000100000,
    PH_SYX_DATA  = 10'b0001000000,
    PH_META_TYPE = 10'b0010000000,
    PH_META_LEN  = 10'b0100000000,
    PH_META_DATA = 10'b1000000000
  } phase_t;

  // One result item as carried between the parser and the output stage.
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] track_index;
    logic [31:0] delta_ticks;
    logic [31:0] total_ticks;
    logic [3:0]  status_nibble;
    logic [3:0]  channel_no;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [23:0] long_value;
    logic        bank_select;
    logic        length_error;
    logic        last_of_run;
  } result_t;

  // Work from one input transfer: up to two results.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } work_t;

endpackage
`default_nettype wire

// File: hdl/mtep_front.sv
`default_nettype none
module mtep_front import mtep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic        kind,
  input  wire logic [31:0] track_length,
  input  wire logic [15:0] track_number,
  input  wire logic [7:0]  data_byte,
  output logic             emit,
  output work_t            work
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] vlq_r, vlq_nxt, delta_r, delta_nxt, total_r, total_nxt;
  logic [31:0] left_r, left_nxt, plen_r, plen_nxt, ppos_r, ppos_nxt;
  logic [3:0]  rnib_r, rnib_nxt, rch_r, rch_nxt;
  logic [7:0]  cur_r, cur_nxt, held_r, held_nxt, mtype_r, mtype_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic        ovr_r, ovr_nxt;

  logic [31:0] vlq_sh;
  logic [31:0] ppos_inc;
  logic [3:0]  bnib;
  logic        n;
  result_t     res [2];

  function automatic result_t mk(input logic [2:0] k, input logic [15:0] tid,
                                 input logic [31:0] dl, input logic [31:0] tt,
                                 input logic [3:0] nb, input logic [3:0] ch,
                                 input logic [7:0] d1, input logic [7:0] d2,
                                 input logic [23:0] lv, input logic bk,
                                 input logic le);
    result_t r;
    r.event_kind = k; r.track_index = tid; r.delta_ticks = dl;
    r.total_ticks = tt; r.status_nibble = nb; r.channel_no = ch;
    r.first_data = d1; r.second_data = d2; r.long_value = lv;
    r.bank_select = bk; r.length_error = le; r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic       cnt;
    logic [7:0] sts, d1, d2;
    logic [3:0] nb;
    logic       bk, fin, ovr_now, left0;
    phase_nxt = phase_r; vlq_nxt = vlq_r; delta_nxt = delta_r;
    total_nxt = total_r; left_nxt = left_r; plen_nxt = plen_r; ppos_nxt = ppos_r;
    rnib_nxt = rnib_r; rch_nxt = rch_r; cur_nxt = cur_r; held_nxt = held_r;
    mtype_nxt = mtype_r; tempo_nxt = tempo_r; tid_nxt = tid_r; ovr_nxt = ovr_r;
    res[0] = '0; res[1] = '0;
    n = 1'b0; cnt = 1'b0; fin = 1'b0;
    sts = cur_r; d1 = '0; d2 = '0; nb = '0; bk = 1'b0;
    vlq_sh = {vlq_r[24:0], data_byte[6:0]};
    ppos_inc = ppos_r + 32'd1;
    bnib = data_byte[7:4];
    ovr_now = ovr_r; left0 = 1'b0;
    emit = 1'b0;
    if (fire) begin
      if (!kind) begin
        phase_nxt = (track_length == '0) ? PH_IDLE : PH_DELTA;
        vlq_nxt = '0; delta_nxt = '0; total_nxt = '0; left_nxt = track_length;
        plen_nxt = '0; ppos_nxt = '0; rnib_nxt = '0; rch_nxt = '0; cur_nxt = '0;
        held_nxt = '0; mtype_nxt = '0; tempo_nxt = '0; tid_nxt = track_number;
        ovr_nxt = 1'b0;
        if (track_length == '0) begin
          res[0] = mk(EV_EXHAUSTED, track_number, '0, '0, '0, '0, '0, '0, '0,
                      1'b0, 1'b0);
          cnt = 1'b1;
        end
      end else if (phase_r == PH_IDLE) begin
        res[0] = mk(EV_STRAY, tid_r, delta_r, total_r, '0, '0, data_byte, '0, '0,
                    1'b0, 1'b0);
        cnt = 1'b1;
      end else begin
        logic chan, stray, syx0, syxend, syxb, mend;
        chan = 1'b0; stray = 1'b0; syx0 = 1'b0; syxend = 1'b0; syxb = 1'b0;
        mend = 1'b0;
        if (left_r == '0) ovr_now = 1'b1;
        else left_nxt = left_r - 32'd1;
        ovr_nxt = ovr_now;
        left0 = (left_nxt == '0);
        unique case (phase_r)
          PH_DELTA: begin
            vlq_nxt = vlq_sh;
            if (!data_byte[7]) begin
              delta_nxt = vlq_sh; total_nxt = total_r + vlq_sh;
              phase_nxt = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (!data_byte[7]) begin
              sts = {rnib_r, rch_r}; cur_nxt = sts;
              if (rnib_r == 4'hC || rnib_r == 4'hD) begin
                chan = 1'b1; d1 = data_byte; d2 = '0;
              end else if (rnib_r >= 4'h8 && rnib_r <= 4'hE) begin
                held_nxt = data_byte; phase_nxt = PH_DATA2;
              end else begin
                stray = 1'b1;
              end
            end else if (bnib != 4'hF) begin
              cur_nxt = data_byte; rnib_nxt = bnib; rch_nxt = data_byte[3:0];
              phase_nxt = PH_DATA1;
            end else if (data_byte == StSysex) begin
              vlq_nxt = '0; phase_nxt = PH_SYX_LEN;
            end else if (data_byte == StMeta) begin
              phase_nxt = PH_META_TYPE;
            end else begin
              fin = 1'b1;
            end
          end
          PH_DATA1: begin
            if (cur_r[7:4] == 4'hC || cur_r[7:4] == 4'hD) begin
              chan = 1'b1; d1 = data_byte; d2 = '0;
            end else begin
              held_nxt = data_byte; phase_nxt = PH_DATA2;
            end
          end
          PH_DATA2: begin
            chan = 1'b1; d1 = held_r; d2 = data_byte;
          end
          PH_SYX_LEN: begin
            vlq_nxt = vlq_sh;
            if (!data_byte[7]) begin
              plen_nxt = vlq_sh; ppos_nxt = '0;
              if (vlq_sh == '0) syx0 = 1'b1;
              else phase_nxt = PH_SYX_DATA;
            end
          end
          PH_SYX_DATA: begin
            if (plen_r == '0 || ppos_r == plen_r - 32'd1) syxend = 1'b1;
            else begin
              syxb = (ppos_r < 32'(SysexKeep));
              ppos_nxt = ppos_inc;
            end
          end
          PH_META_TYPE: begin
            mtype_nxt = data_byte; vlq_nxt = '0; phase_nxt = PH_META_LEN;
          end
          PH_META_LEN: begin
            vlq_nxt = vlq_sh;
            if (!data_byte[7]) begin
              plen_nxt = vlq_sh; ppos_nxt = '0; tempo_nxt = '0;
              if (vlq_sh == '0) mend = 1'b1;
              else phase_nxt = PH_META_DATA;
            end
          end
          PH_META_DATA: begin
            if (mtype_r == MetaTempo) tempo_nxt = {tempo_r[15:0], data_byte};
            ppos_nxt = ppos_inc;
            if (ppos_inc == plen_r) mend = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (chan) begin
          nb = sts[7:4];
          if (nb == 4'h9 && d2 == '0) nb = 4'h8;
          if (nb == 4'hB && (d1 == 8'd0 || d1 == 8'd32)) begin
            d1 = d2; d2 = '0; bk = 1'b1;
          end
          res[0] = mk(EV_CHAN, tid_r, delta_nxt, total_nxt, nb, sts[3:0], d1, d2,
                      '0, bk, ovr_now);
          cnt = 1'b1; fin = 1'b1;
        end
        if (stray) begin
          res[0] = mk(EV_STRAY, tid_r, delta_nxt, total_nxt, '0, '0, data_byte, '0,
                      '0, 1'b0, ovr_now);
          cnt = 1'b1; fin = 1'b1;
        end
        if (syx0) begin
          res[0] = mk(EV_SYX_END, tid_r, delta_nxt, total_nxt, '0, '0, '0, '0, '0,
                      1'b0, ovr_now);
          cnt = 1'b1; fin = 1'b1;
        end
        if (syxend) begin
          res[0] = mk(EV_SYX_END, tid_r, delta_nxt, total_nxt, '0, '0,
                      (ppos_r < 32'(SysexKeep)) ? data_byte : 8'd0, '0,
                      (plen_r < 32'(SysexKeep)) ? plen_r[23:0] : 24'(SysexKeep),
                      1'b0, ovr_now);
          cnt = 1'b1; fin = 1'b1;
        end
        if (syxb) begin
          res[0] = mk(EV_SYX_BYTE, tid_r, delta_nxt, total_nxt, '0, '0, data_byte,
                      '0, ppos_r[23:0], 1'b0, ovr_now);
          cnt = 1'b1;
        end
        if (mend) begin
          if (mtype_nxt == MetaTempo) begin
            res[0] = mk(EV_TEMPO, tid_r, delta_nxt, total_nxt, '0, '0, '0, '0,
                        tempo_nxt, 1'b0, ovr_now);
            cnt = 1'b1; fin = 1'b1;
          end else if (mtype_nxt == MetaEot) begin
            res[0] = mk(EV_END_TRACK, tid_r, delta_nxt, total_nxt, '0, '0, '0, '0,
                        '0, 1'b0, ovr_now | ~left0);
            cnt = 1'b1; phase_nxt = PH_IDLE;
          end else begin
            fin = 1'b1;
          end
        end
        if (fin) begin
          if (ovr_now || left0) begin
            phase_nxt = PH_IDLE;
            if (cnt) begin
              res[1] = mk(EV_EXHAUSTED, tid_r, delta_nxt, total_nxt, '0, '0, '0,
                          '0, '0, 1'b0, ovr_now);
              n = 1'b1;
            end else begin
              res[0] = mk(EV_EXHAUSTED, tid_r, delta_nxt, total_nxt, '0, '0, '0,
                          '0, '0, 1'b0, ovr_now);
              cnt = 1'b1;
            end
          end else begin
            phase_nxt = PH_DELTA; vlq_nxt = '0;
          end
        end
      end
      emit = cnt;
    end
    if (n) res[1].last_of_run = 1'b1;
    else res[0].last_of_run = 1'b1;
    work.two = n;
    work.r0 = res[0];
    work.r1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; vlq_r <= '0; delta_r <= '0; total_r <= '0; left_r <= '0;
      plen_r <= '0; ppos_r <= '0; rnib_r <= '0; rch_r <= '0; cur_r <= '0;
      held_r <= '0; mtype_r <= '0; tempo_r <= '0; tid_r <= '0; ovr_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; vlq_r <= vlq_nxt; delta_r <= delta_nxt;
      total_r <= total_nxt; left_r <= left_nxt; plen_r <= plen_nxt;
      ppos_r <= ppos_nxt; rnib_r <= rnib_nxt; rch_r <= rch_nxt; cur_r <= cur_nxt;
      held_r <= held_nxt; mtype_r <= mtype_nxt; tempo_r <= tempo_nxt;
      tid_r <= tid_nxt; ovr_r <= ovr_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("phase not one-hot");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
      fire && !kind |=> !ovr_r) else $error("overrun survived track start");
  a_two: assert property (@(posedge clk) disable iff (!rst_n)
      work.two |-> work.r1.event_kind == EV_EXHAUSTED)
    else $error("second result is not length exhausted");

endmodule
`default_nettype wire

// File: hdl/mtep_back.sv
`default_nettype none
module mtep_back import mtep_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  work_t     push_work,
  output logic      space,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  work_t            mem_r [Depth];
  logic [Aw-1:0]    wp_r, rp_r;
  logic [Aw:0]      cnt_r;
  logic             sub_r;
  logic             pop;
  work_t            head;

  assign head = mem_r[rp_r];
  assign res_valid = (cnt_r != '0);
  assign res = sub_r ? head.r1 : head.r0;
  // Ready while at least one slot is free, so a push never overflows.
  assign space = (cnt_r < (Aw+1)'(Depth));
  assign pop = res_valid && res_ready && (!head.two || sub_r);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_work;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= 1'b0;
    end else begin
      if (push) wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + Aw'(1);
      if (pop) rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + Aw'(1);
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
      if (res_valid && res_ready) sub_r <= head.two && !sub_r;
    end
  end

  a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
      push |-> cnt_r < (Aw+1)'(Depth)) else $error("queue overflow");
  a_sub: assert property (@(posedge clk) disable iff (!rst_n)
      sub_r |-> res_valid && head.two) else $error("bad second-result state");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r == '0 |-> !sub_r) else $error("sub index set on empty queue");

endmodule
`default_nettype wire

// File: hdl/midi_track_event_parser.sv
`default_nettype none
// Channel  Dir  Fields
// in_      in   tdata: track_length[31:0] track_number[47:32] data_byte[55:48]; tuser: kind
// out_     out  tuser: event_kind; tdata: track_index .. length_error (see port);
//               tlast: last_of_run
//
// Each input transfer is parsed in the cycle it is accepted; the front end has
// no multi-cycle work, so one byte is taken every cycle while the queue has space.
// A result is queued as its transfer is accepted and is offered on out_ once the
// earlier entries have drained. Results go into a four-entry queue; an item that
// causes two results drains as two output transfers, so the sustained rate is set
// by the output side. in_tready drops only when the queue is full. Reset (rst_n
// low, synchronous) puts the parser idle with no track open and empties the queue.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // track_length[31:0], track_number[47:32], data_byte[55:48]
  input  wire logic [55:0]  in_tdata,
  // kind
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // track_index[15:0], delta_ticks[47:16], total_ticks[79:48],
  // status_nibble[83:80], channel_no[87:84], first_data[95:88],
  // second_data[103:96], long_value[127:104], bank_select[128],
  // length_error[129], zero fill [135:130]
  output logic [135:0]      out_tdata,
  // event_kind[2:0]
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  logic    fire, emit, space;
  work_t   work;
  result_t res;

  assign in_tready = space;
  assign fire = in_tvalid && in_tready;

  mtep_front u_front (
    .clk(clk), .rst_n(rst_n), .fire(fire), .kind(in_tuser),
    .track_length(in_tdata[31:0]), .track_number(in_tdata[47:32]),
    .data_byte(in_tdata[55:48]), .emit(emit), .work(work)
  );

  mtep_back #(.Depth(QDepth)) u_back (
    .clk(clk), .rst_n(rst_n), .push(emit), .push_work(work), .space(space),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {6'b000000, res.length_error, res.bank_select, res.long_value,
                      res.second_data, res.first_data, res.channel_no,
                      res.status_nibble, res.total_ticks, res.delta_ticks,
                      res.track_index};
  assign out_tuser = res.event_kind;
  assign out_tlast = res.last_of_run;

endmodule
`default_nettype wire
